FILE: rtl/gpc_pkg.sv
`timescale 1ns / 1ps

package gpc_pkg;

  localparam int unsigned MaxPins         = 16;
  localparam int unsigned PinCountDefault = 16;
  localparam int unsigned PinIdxW         = 4;
  localparam int unsigned MsW             = 16;
  localparam int unsigned CfgIdxW         = 2;

  localparam logic [PinIdxW-1:0] BridgePinA = 4'd12;
  localparam logic [PinIdxW-1:0] BridgePinB = 4'd14;
  localparam logic [PinIdxW-1:0] NoPin      = 4'd0;

  localparam logic [MsW-1:0] DefaultDelayReset = 16'd200;

  typedef enum logic [1:0] {
    FUNC_TRIGGER   = 2'd0,
    FUNC_TOGGLE    = 2'd1,
    FUNC_RESET_ALL = 2'd2,
    FUNC_TICK      = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_PIN    = 3'd1,
    ST_UNAUTH    = 3'd2,
    ST_BUSY      = 3'd3,
    ST_INTERLOCK = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_AUTH_MASK     = 2'd0,
    REG_DEFAULT_DELAY = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [PinIdxW-1:0] pin;
    logic               inverted;
    logic [MsW-1:0]     delay_ms;
    logic [MsW-1:0]     elapsed_ms;
  } gpc_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               pin_level;
    logic [MaxPins-1:0] pin_levels;
  } gpc_out_t;

  typedef struct packed {
    logic           step;
    logic           load;
    logic [MsW-1:0] value;
  } gpc_tmr_ctrl_t;

endpackage

FILE: rtl/gpc_timers.sv
`timescale 1ns / 1ps

module gpc_timers #(
  parameter int unsigned PinCount = gpc_pkg::PinCountDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gpc_pkg::gpc_in_t      cmd_i,
  input  gpc_pkg::gpc_tmr_ctrl_t ctrl_i,
  input  logic [PinCount-1:0]   auth_i,
  output logic [PinCount-1:0]   active_o,
  output logic [PinCount-1:0]   flip_o
);

  logic sweep;
  logic reset_all;

  assign sweep     = (cmd_i.func == gpc_pkg::FUNC_RESET_ALL) ||
                     (cmd_i.func == gpc_pkg::FUNC_TICK);
  assign reset_all = (cmd_i.func == gpc_pkg::FUNC_RESET_ALL);

  for (genvar i = 0; i < PinCount; i++) begin : g_lane
    logic [gpc_pkg::MsW-1:0] remaining_q;
    logic [gpc_pkg::MsW-1:0] remaining_d;
    logic                    hit;
    logic                    expired;
    logic                    counting;

    assign active_o[i] = (remaining_q != '0);
    assign hit         = ctrl_i.load && (cmd_i.pin == gpc_pkg::PinIdxW'(i));
    assign expired     = reset_all || (remaining_q <= cmd_i.elapsed_ms);
    assign counting    = sweep && auth_i[i] && active_o[i];
    assign flip_o[i]   = counting && expired;

    always_comb begin
      remaining_d = remaining_q;
      if (ctrl_i.step) begin
        if (hit) begin
          remaining_d = ctrl_i.value;
        end else if (counting) begin
          remaining_d = expired ? '0 : (remaining_q - cmd_i.elapsed_ms);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        remaining_q <= '0;
      end else begin
        remaining_q <= remaining_d;
      end
    end
  end

endmodule

FILE: rtl/gpc_cmd.sv
`timescale 1ns / 1ps

module gpc_cmd #(
  parameter int unsigned PinCount = gpc_pkg::PinCountDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  gpc_pkg::gpc_in_t                cmd_i,
  input  logic [gpc_pkg::MaxPins-1:0]     auth_i,
  input  logic [gpc_pkg::MsW-1:0]         default_delay_i,
  input  logic [PinCount-1:0]             active_i,
  input  logic [PinCount-1:0]             flip_i,
  output gpc_pkg::gpc_tmr_ctrl_t          ctrl_o,
  output gpc_pkg::gpc_out_t               result_o
);

  logic [PinCount-1:0]             levels_q;
  logic [PinCount-1:0]             levels_d;
  logic [gpc_pkg::MaxPins-1:0]     lv16;
  logic [gpc_pkg::MaxPins-1:0]     active16;
  logic [gpc_pkg::MaxPins-1:0]     flip16;
  logic [gpc_pkg::MaxPins-1:0]     new_lv;
  gpc_pkg::status_e                status;
  logic                            lvl;
  logic                            lvl_out;
  logic                            partner_hi;
  logic                            load;

  assign lv16     = gpc_pkg::MaxPins'(levels_q);
  assign active16 = gpc_pkg::MaxPins'(active_i);
  assign flip16   = gpc_pkg::MaxPins'(flip_i);

  always_comb begin
    status     = gpc_pkg::ST_OK;
    lvl        = 1'b0;
    lvl_out    = 1'b0;
    partner_hi = 1'b0;
    load       = 1'b0;
    new_lv     = lv16;
    unique case (gpc_pkg::func_e'(cmd_i.func)) inside
      gpc_pkg::FUNC_TRIGGER, gpc_pkg::FUNC_TOGGLE: begin
        lvl = (cmd_i.func == gpc_pkg::FUNC_TRIGGER) ? !cmd_i.inverted : !lv16[cmd_i.pin];
        partner_hi = ((cmd_i.pin == gpc_pkg::BridgePinA) && lv16[gpc_pkg::BridgePinB]) ||
                     ((cmd_i.pin == gpc_pkg::BridgePinB) && lv16[gpc_pkg::BridgePinA]);
        if (cmd_i.pin == gpc_pkg::NoPin) begin
          status = gpc_pkg::ST_NO_PIN;
        end else if (!auth_i[cmd_i.pin]) begin
          status = gpc_pkg::ST_UNAUTH;
        end else if (active16[cmd_i.pin]) begin
          status = gpc_pkg::ST_BUSY;
        end else if (lvl && partner_hi) begin
          status = gpc_pkg::ST_INTERLOCK;
        end else begin
          new_lv[cmd_i.pin] = lvl;
          lvl_out           = lvl;
          load              = (cmd_i.func == gpc_pkg::FUNC_TRIGGER);
        end
      end
      gpc_pkg::FUNC_RESET_ALL, gpc_pkg::FUNC_TICK: begin
        // The lower bridge pin is handled first, so the upper one sees its new level.
        new_lv = lv16 ^ flip16;
        new_lv[gpc_pkg::BridgePinA] = flip16[gpc_pkg::BridgePinA] ?
            (!lv16[gpc_pkg::BridgePinA] && !lv16[gpc_pkg::BridgePinB]) :
            lv16[gpc_pkg::BridgePinA];
        new_lv[gpc_pkg::BridgePinB] = flip16[gpc_pkg::BridgePinB] ?
            (!lv16[gpc_pkg::BridgePinB] && !new_lv[gpc_pkg::BridgePinA]) :
            lv16[gpc_pkg::BridgePinB];
      end
      default: begin
        status = gpc_pkg::ST_OK;
      end
    endcase
  end

  assign levels_d = new_lv[PinCount-1:0];

  assign ctrl_o.step  = step_i;
  assign ctrl_o.load  = load;
  assign ctrl_o.value = (cmd_i.delay_ms != '0) ? cmd_i.delay_ms : default_delay_i;

  assign result_o.status     = status;
  assign result_o.pin_level  = lvl_out;
  assign result_o.pin_levels = gpc_pkg::MaxPins'(levels_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= '0;
    end else if (step_i) begin
      levels_q <= levels_d;
    end
  end

endmodule

FILE: rtl/gpio_pulse_controller_interlock_core.sv
`timescale 1ns / 1ps
// A request is registered in the input register, and its result in the output register.
// Throughput: one request per cycle unless the output stalls; timer bank and pin levels update together.
// Output stalls back up through the input register with no bubbles.
// Reset clears all pin levels, every pulse timer and the authorized mask,
// and sets the default delay to 200 ms.
module gpio_pulse_controller_interlock_core #(
  parameter int unsigned PinCount = gpc_pkg::PinCountDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  gpc_pkg::gpc_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output gpc_pkg::gpc_out_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [gpc_pkg::MsW-1:0]      cfg_data_i
);

  localparam logic [gpc_pkg::MaxPins-1:0] PresentMask =
      gpc_pkg::MaxPins'((17'd1 << PinCount) - 17'd1);

  logic                        s1_valid_q;
  gpc_pkg::gpc_in_t            s1_data_q;
  logic                        out_valid_q;
  gpc_pkg::gpc_out_t           out_data_q;
  logic [gpc_pkg::MsW-1:0]     auth_mask_q;
  logic [gpc_pkg::MsW-1:0]     default_delay_q;
  logic [gpc_pkg::MaxPins-1:0] auth;
  logic                        step;
  logic [PinCount-1:0]         active;
  logic [PinCount-1:0]         flip;
  gpc_pkg::gpc_tmr_ctrl_t      tmr_ctrl;
  gpc_pkg::gpc_out_t           result;

  assign auth        = auth_mask_q & PresentMask;
  assign step        = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auth_mask_q     <= '0;
      default_delay_q <= gpc_pkg::DefaultDelayReset;
    end else if (cfg_valid_i) begin
      unique case (gpc_pkg::cfg_reg_e'(cfg_index_i))
        gpc_pkg::REG_AUTH_MASK:     auth_mask_q     <= cfg_data_i;
        gpc_pkg::REG_DEFAULT_DELAY: default_delay_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= result;
    end
  end

  gpc_timers #(
    .PinCount(PinCount)
  ) u_timers (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (s1_data_q),
    .ctrl_i  (tmr_ctrl),
    .auth_i  (auth[PinCount-1:0]),
    .active_o(active),
    .flip_o  (flip)
  );

  gpc_cmd #(
    .PinCount(PinCount)
  ) u_cmd (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .cmd_i          (s1_data_q),
    .auth_i         (auth),
    .default_delay_i(default_delay_q),
    .active_i       (active),
    .flip_i         (flip),
    .ctrl_o         (tmr_ctrl),
    .result_o       (result)
  );

`ifndef SYNTHESIS
  a_bridge_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.pin_levels[gpc_pkg::BridgePinA] &&
                      out_data_o.pin_levels[gpc_pkg::BridgePinB]))
    else $error("bridge pins both high");

  a_refused_level_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != gpc_pkg::ST_OK)) |-> !out_data_o.pin_level)
    else $error("refused request reports a high pin level");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !step) |=> (s1_valid_q && $stable(s1_data_q)))
    else $error("pending request lost from the input register");
`endif

endmodule
